### rtl/hse_pkg.sv
// Package for the heap sort engine: sequencer states and data width.
// Used by rtl/heap_sort_engine_unit.sv; depends on nothing.
`default_nettype none

package hse_pkg;

  localparam int unsigned DATA_W = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_NEXT,
    ST_SIFT_LDV,
    ST_SIFT_CHK,
    ST_SIFT_RL,
    ST_SIFT_RR,
    ST_SIFT_CMP,
    ST_SORT_NEXT,
    ST_SORT_RD0,
    ST_SORT_WR,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

endpackage

`default_nettype wire

### rtl/heap_sort_engine_unit.sv
// Heap sort engine: loads signed values, heap-sorts them in place, emits ascending.
// Depends on rtl/hse_pkg.sv.
//
//   channel   ports                                   direction  handshake
//   request   start, value_i, last_i                  in         start && !busy
//   result    result_strobe_o, sorted_value_o,        out        strobe, one cycle
//             end_of_run_o, overflow_o
//
// Loading accepts one request per cycle while busy is low. A request with last_i set
// starts the sort, which runs on one shared signed comparator and a one-write, one-read
// store: each sift level reads the children, makes up to two compares and writes back,
// and each result is read from the store before it is issued.
// busy is high from the last request until the final result has been issued.
// Reset clears the sequencer, fill count and overflow flag; the store is not cleared.
// Results cannot be stalled: each one is on the ports for exactly one cycle.
`default_nettype none

module heap_sort_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic [hse_pkg::DATA_W-1:0] value_i,
  input  wire logic                      last_i,
  output      logic                      result_strobe_o,
  output      logic [hse_pkg::DATA_W-1:0] sorted_value_o,
  output      logic                      end_of_run_o,
  output      logic                      overflow_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = AW + 2;
  localparam int unsigned DW = hse_pkg::DATA_W;

  // Store, read data register
  logic [DW-1:0] mem_q [CAPACITY];
  logic [DW-1:0] rd_q;

  // Control state
  hse_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q;
  logic            drop_q;
  logic            sort_phase_q;
  logic            strobe_q;

  // Datapath registers
  logic [CW-1:0] n_q, k_q, len_q, idx_q;
  logic [AW-1:0] pos_q, big_idx_q;
  logic [DW-1:0] v_q, big_q;
  logic [DW-1:0] out_val_q;
  logic          out_end_q;
  logic          out_ovf_q;

  // Memory port control
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic accept;
  logic not_full;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] k_m1;
  logic [LW-1:0] l_ext, r_ext, len_ext;
  logic          has_left, has_right;
  logic          sift_end;
  logic          emit_last;
  logic [DW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;

  assign accept    = start && !busy;
  assign not_full  = (count_q < CW'(CAPACITY));
  assign count_inc = count_q + CW'(1);
  assign k_m1      = k_q - CW'(1);
  assign l_ext     = {1'b0, pos_q, 1'b1};
  assign r_ext     = l_ext + LW'(1);
  assign len_ext   = LW'(len_q);
  assign has_left  = (l_ext < len_ext);
  assign has_right = (r_ext < len_ext);
  assign emit_last = ((idx_q + CW'(1)) == n_q);

  // Shared signed comparator: right child vs left, then sifted value vs larger child
  always_comb begin
    cmp_a = v_q;
    cmp_b = big_q;
    if (state_q == hse_pkg::ST_SIFT_RR) begin
      cmp_a = big_q;
      cmp_b = rd_q;
    end
  end
  assign cmp_lt = ($signed(cmp_a) < $signed(cmp_b));

  // A sift ends when the node has no child or already dominates its children
  assign sift_end = ((state_q == hse_pkg::ST_SIFT_CHK) && !has_left) ||
                    ((state_q == hse_pkg::ST_SIFT_CMP) && !cmp_lt);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hse_pkg::ST_IDLE: begin
        if (accept && last_i) state_d = hse_pkg::ST_BUILD_NEXT;
      end
      hse_pkg::ST_BUILD_NEXT: begin
        if (k_q == '0) state_d = hse_pkg::ST_SORT_NEXT;
        else           state_d = hse_pkg::ST_SIFT_LDV;
      end
      hse_pkg::ST_SIFT_LDV: state_d = hse_pkg::ST_SIFT_CHK;
      hse_pkg::ST_SIFT_CHK: begin
        if (!has_left) state_d = sort_phase_q ? hse_pkg::ST_SORT_NEXT : hse_pkg::ST_BUILD_NEXT;
        else           state_d = hse_pkg::ST_SIFT_RL;
      end
      hse_pkg::ST_SIFT_RL: begin
        if (has_right) state_d = hse_pkg::ST_SIFT_RR;
        else           state_d = hse_pkg::ST_SIFT_CMP;
      end
      hse_pkg::ST_SIFT_RR: state_d = hse_pkg::ST_SIFT_CMP;
      hse_pkg::ST_SIFT_CMP: begin
        if (!cmp_lt) state_d = sort_phase_q ? hse_pkg::ST_SORT_NEXT : hse_pkg::ST_BUILD_NEXT;
        else         state_d = hse_pkg::ST_SIFT_CHK;
      end
      hse_pkg::ST_SORT_NEXT: begin
        if (k_q <= CW'(1)) state_d = hse_pkg::ST_EMIT_RD;
        else               state_d = hse_pkg::ST_SORT_RD0;
      end
      hse_pkg::ST_SORT_RD0: state_d = hse_pkg::ST_SORT_WR;
      hse_pkg::ST_SORT_WR:  state_d = hse_pkg::ST_SIFT_CHK;
      hse_pkg::ST_EMIT_RD:  state_d = hse_pkg::ST_EMIT_OUT;
      hse_pkg::ST_EMIT_OUT: begin
        if (emit_last) state_d = hse_pkg::ST_IDLE;
        else           state_d = hse_pkg::ST_EMIT_RD;
      end
      default: state_d = hse_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store port control and busy
  always_comb begin
    busy      = (state_q != hse_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = v_q;
    mem_raddr = pos_q;
    case (state_q)
      hse_pkg::ST_IDLE: begin
        mem_we    = accept && not_full;
        mem_waddr = count_q[AW-1:0];
        mem_wdata = value_i;
      end
      hse_pkg::ST_BUILD_NEXT: mem_raddr = k_m1[AW-1:0];
      hse_pkg::ST_SIFT_CHK: begin
        mem_we    = !has_left;
        mem_raddr = l_ext[AW-1:0];
      end
      hse_pkg::ST_SIFT_RL: mem_raddr = r_ext[AW-1:0];
      hse_pkg::ST_SIFT_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = cmp_lt ? big_q : v_q;
      end
      hse_pkg::ST_SORT_NEXT: mem_raddr = k_m1[AW-1:0];
      hse_pkg::ST_SORT_RD0:  mem_raddr = '0;
      hse_pkg::ST_SORT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_m1[AW-1:0];
        mem_wdata = rd_q;
      end
      hse_pkg::ST_EMIT_RD: mem_raddr = idx_q[AW-1:0];
      default: ;
    endcase
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hse_pkg::ST_IDLE;
      count_q      <= '0;
      drop_q       <= 1'b0;
      sort_phase_q <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == hse_pkg::ST_EMIT_OUT);
      if (accept) begin
        sort_phase_q <= 1'b0;
        if (not_full) count_q <= count_inc;
        else          drop_q  <= 1'b1;
      end
      if (state_q == hse_pkg::ST_BUILD_NEXT && k_q == '0) sort_phase_q <= 1'b1;
      if (state_q == hse_pkg::ST_EMIT_OUT && emit_last) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      hse_pkg::ST_IDLE: begin
        if (accept) begin
          n_q <= not_full ? count_inc : count_q;
          k_q <= (not_full ? count_inc : count_q) >> 1;
        end
      end
      hse_pkg::ST_BUILD_NEXT: begin
        if (k_q == '0) begin
          k_q <= n_q;
        end else begin
          pos_q <= k_m1[AW-1:0];
          len_q <= n_q;
        end
      end
      hse_pkg::ST_SIFT_LDV: v_q <= rd_q;
      hse_pkg::ST_SIFT_RL: begin
        big_q     <= rd_q;
        big_idx_q <= l_ext[AW-1:0];
      end
      hse_pkg::ST_SIFT_RR: begin
        if (cmp_lt) begin
          big_q     <= rd_q;
          big_idx_q <= r_ext[AW-1:0];
        end
      end
      hse_pkg::ST_SIFT_CMP: begin
        if (cmp_lt) pos_q <= big_idx_q;
      end
      hse_pkg::ST_SORT_NEXT: idx_q <= '0;
      hse_pkg::ST_SORT_RD0:  v_q <= rd_q;
      hse_pkg::ST_SORT_WR: begin
        pos_q <= '0;
        len_q <= k_m1;
      end
      hse_pkg::ST_EMIT_OUT: begin
        out_val_q <= rd_q;
        out_end_q <= emit_last;
        out_ovf_q <= drop_q;
        idx_q     <= idx_q + CW'(1);
      end
      default: ;
    endcase
    if (sift_end) k_q <= k_m1;
  end

  assign result_strobe_o = strobe_q;
  assign sorted_value_o  = out_val_q;
  assign end_of_run_o    = out_end_q & strobe_q;
  assign overflow_o      = out_ovf_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_sift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hse_pkg::ST_SIFT_CHK) |-> (LW'(pos_q) < len_ext))
    else $error("sift position outside heap");

  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == hse_pkg::ST_EMIT_OUT))
    else $error("result strobe without emit step");

  a_run_clears_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_run_o |-> (count_q == '0 && !drop_q && state_q == hse_pkg::ST_IDLE))
    else $error("set not cleared after final result");

endmodule

`default_nettype wire
